[src/h_bridge_safe_reversal_controller_unit_defines.svh]
// Assertion macros for the checker file of the H-bridge controller.
`ifndef H_BRIDGE_SAFE_REVERSAL_CONTROLLER_UNIT_DEFINES_SVH
`define H_BRIDGE_SAFE_REVERSAL_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HBSRC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbsrc assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HBSRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbsrc assertion failed");

`endif

[src/hbsrc_pkg.sv]
// Package: payload types, sequencer states and constants of the H-bridge controller.
package hbsrc_pkg;

   localparam int SAMPLE_MAX_DEFAULT = 4095;
   localparam int DUTY_BITS_DEFAULT  = 8;

   localparam int PCT_SCALE  = 100;

   localparam logic DIR_RIGHT = 1'b0;
   localparam logic DIR_LEFT  = 1'b1;

   localparam logic CSR_DEAD_TICKS = 1'b0;
   localparam logic CSR_PWM_MAX    = 1'b1;

   localparam logic [7:0] DEAD_TICKS_RESET = 8'd15;
   localparam logic [7:0] PWM_MAX_RESET    = 8'd255;

   typedef struct packed {
      logic        right_button;
      logic        left_button;
      logic [11:0] speed_sample;
   } req_payload_type;

   typedef struct packed {
      logic       high_side_left;
      logic       high_side_right;
      logic [7:0] duty_left;
      logic [7:0] duty_right;
      logic       led_right;
      logic       led_red;
      logic [6:0] speed_percent;
      logic       reversing;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PCT,
      ST_MUL,
      ST_OUT
   } hbsrc_state_type;

endpackage

[src/h_bridge_safe_reversal_controller_unit.sv]
// H-bridge direction controller with dead time on reversal, one tick per word.
// An accepted req word is registered, then makes three passes through the shared
// multiplier (percent, duty product, duty scale) before its rsp word is registered;
// req_ready stays low until then, so only one word is in flight at a time.
// A stalled rsp word holds the sequencer in its output step until taken.
// Reset (synchronous, active high): no rsp word valid, direction right, no dead time.
module h_bridge_safe_reversal_controller_unit #(
   parameter int SAMPLE_MAX = hbsrc_pkg::SAMPLE_MAX_DEFAULT,
   parameter int DUTY_BITS  = hbsrc_pkg::DUTY_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  hbsrc_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output hbsrc_pkg::rsp_payload_type rsp_payload,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [7:0]                 csr_wdata
);

   // Reciprocal scaling: x / d equals (x * ceil(2^k / d)) >> k for every x below n
   // as long as 2^k >= n * d, so each division is one multiply and a fixed shift.
   localparam longint PCT_SPAN   = longint'(hbsrc_pkg::PCT_SCALE * SAMPLE_MAX + 1);
   localparam int     PCT_SHIFT  = $clog2(PCT_SPAN * longint'(SAMPLE_MAX));
   localparam longint PCT_RECIP  =
      ((longint'(1) << PCT_SHIFT) + longint'(SAMPLE_MAX - 1)) / longint'(SAMPLE_MAX);
   // duty dividend: percent times the largest pwm_max
   localparam longint DUTY_SPAN  = longint'(hbsrc_pkg::PCT_SCALE * 255 + 1);
   localparam int     DUTY_SHIFT = $clog2(DUTY_SPAN * longint'(hbsrc_pkg::PCT_SCALE));
   localparam longint DUTY_RECIP =
      ((longint'(1) << DUTY_SHIFT) + longint'(hbsrc_pkg::PCT_SCALE - 1))
      / longint'(hbsrc_pkg::PCT_SCALE);

   // Shared multiplier operand widths
   localparam int SCALED_W = $clog2(PCT_SPAN);
   localparam int PROD_W   = $clog2(DUTY_SPAN);
   localparam int OPA_W    = (SCALED_W > PROD_W) ? SCALED_W : PROD_W;
   localparam int RPCT_W   = $clog2(PCT_RECIP + 1);
   localparam int RDUTY_W  = $clog2(DUTY_RECIP + 1);
   localparam int OPB_W    = (RPCT_W > RDUTY_W) ? RPCT_W : RDUTY_W;
   localparam int MUL_W    = OPA_W + OPB_W;

   localparam logic [OPA_W-1:0] SMAX_EXT     = OPA_W'(SAMPLE_MAX);
   localparam logic [OPB_W-1:0] PCT_RECIP_B  = OPB_W'(PCT_RECIP);
   localparam logic [OPB_W-1:0] DUTY_RECIP_B = OPB_W'(DUTY_RECIP);
   localparam logic [16:0]      DUTY_MAX     = 17'((1 << DUTY_BITS) - 1);

   // Configuration registers
   logic [7:0] dead_ticks_ff;
   logic [7:0] pwm_max_ff;

   // Control state of the reversal logic
   logic       prev_right_ff, prev_right_in;
   logic       prev_left_ff, prev_left_in;
   logic       committed_dir_ff, committed_dir_in;
   logic       requested_dir_ff, requested_dir_in;
   logic [7:0] dead_count_ff, dead_count_in;
   logic       off_ff, off_in;

   // Sequencer and shared multiplier
   hbsrc_pkg::hbsrc_state_type state_ff, state_in;
   logic [OPA_W-1:0] opnd_ff, opnd_in;
   logic [6:0]       pct_ff, pct_in;
   logic [OPB_W-1:0] mul_b;
   logic [MUL_W-1:0] mul_p;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   hbsrc_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Tick decision, taken from the incoming word and the control state
   logic       ctl_off;
   logic       ctl_committed;
   logic       ctl_requested;
   logic [7:0] ctl_dead;

   // Scaling values
   logic [OPA_W-1:0] sample_clamp;
   logic [OPA_W-1:0] sample_scaled;
   logic [6:0]       pct_q;
   logic [7:0]       duty_q;
   logic [7:0]       duty_sat;

   assign req_ready   = (state_ff == hbsrc_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ticks_ff <= hbsrc_pkg::DEAD_TICKS_RESET;
         pwm_max_ff    <= hbsrc_pkg::PWM_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hbsrc_pkg::CSR_DEAD_TICKS: dead_ticks_ff <= csr_wdata;
            hbsrc_pkg::CSR_PWM_MAX:    pwm_max_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Reversal decision: a running dead time counts down and commits on its last
   // tick; otherwise a falling button edge requests a direction, left winning.
   always_comb begin
      ctl_off       = 1'b0;
      ctl_committed = committed_dir_ff;
      ctl_requested = requested_dir_ff;
      ctl_dead      = dead_count_ff;
      if (dead_count_ff != 8'd0) begin
         ctl_dead = dead_count_ff - 8'd1;
         if (ctl_dead == 8'd0) begin
            ctl_committed = requested_dir_ff;
         end else begin
            ctl_off = 1'b1;
         end
      end else begin
         if (prev_right_ff && !req_payload.right_button) begin
            ctl_requested = hbsrc_pkg::DIR_RIGHT;
         end
         if (prev_left_ff && !req_payload.left_button) begin
            ctl_requested = hbsrc_pkg::DIR_LEFT;
         end
         if (ctl_requested != committed_dir_ff) begin
            // a zero setting acts as a single dead tick
            ctl_dead = (dead_ticks_ff == 8'd0) ? 8'd1 : dead_ticks_ff;
            ctl_off  = 1'b1;
         end
      end
   end

   // Clamp the sample and scale by one hundred with shifts (64 + 32 + 4)
   always_comb begin
      sample_clamp  = OPA_W'(req_payload.speed_sample);
      if (sample_clamp > SMAX_EXT) begin
         sample_clamp = SMAX_EXT;
      end
      sample_scaled = (sample_clamp << 6) + (sample_clamp << 5) + (sample_clamp << 2);
   end

   // Shared multiplier: operand A is always the held operand, B follows the step
   always_comb begin
      case (state_ff)
         hbsrc_pkg::ST_PCT: mul_b = PCT_RECIP_B;
         hbsrc_pkg::ST_MUL: mul_b = OPB_W'(pwm_max_ff);
         default:           mul_b = DUTY_RECIP_B;
      endcase
   end

   assign mul_p    = {{OPB_W{1'b0}}, opnd_ff} * {{OPA_W{1'b0}}, mul_b};
   assign pct_q    = mul_p[PCT_SHIFT +: 7];
   assign duty_q   = mul_p[DUTY_SHIFT +: 8];
   assign duty_sat = ({9'd0, duty_q} > DUTY_MAX) ? DUTY_MAX[7:0] : duty_q;

   // Sequencer: next state, multiplier operands and the output word
   always_comb begin
      state_in         = state_ff;
      opnd_in          = opnd_ff;
      pct_in           = pct_ff;
      prev_right_in    = prev_right_ff;
      prev_left_in     = prev_left_ff;
      committed_dir_in = committed_dir_ff;
      requested_dir_in = requested_dir_ff;
      dead_count_in    = dead_count_ff;
      off_in           = off_ff;
      rsp_payload_in   = rsp_payload_ff;
      rsp_valid_in     = rsp_valid_ff;

      // drop the word once the consumer takes it
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         hbsrc_pkg::ST_IDLE: begin
            if (req_valid) begin
               // advance the control state and hold the scaled sample
               prev_right_in    = req_payload.right_button;
               prev_left_in     = req_payload.left_button;
               committed_dir_in = ctl_committed;
               requested_dir_in = ctl_requested;
               dead_count_in    = ctl_dead;
               off_in           = ctl_off;
               opnd_in          = sample_scaled;
               state_in         = hbsrc_pkg::ST_PCT;
            end
         end
         hbsrc_pkg::ST_PCT: begin
            // percent = sample * 100 / SAMPLE_MAX
            pct_in   = pct_q;
            opnd_in  = OPA_W'(pct_q);
            state_in = hbsrc_pkg::ST_MUL;
         end
         hbsrc_pkg::ST_MUL: begin
            // hold percent * pwm_max for the final division by one hundred
            opnd_in  = OPA_W'(mul_p[PROD_W-1:0]);
            state_in = hbsrc_pkg::ST_OUT;
         end
         hbsrc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_payload_in = '0;
               if (!off_ff && duty_sat != 8'd0) begin
                  if (committed_dir_ff == hbsrc_pkg::DIR_RIGHT) begin
                     rsp_payload_in.high_side_left = 1'b1;
                     rsp_payload_in.duty_right     = duty_sat;
                  end else begin
                     rsp_payload_in.high_side_right = 1'b1;
                     rsp_payload_in.duty_left       = duty_sat;
                  end
               end
               rsp_payload_in.led_right     = (committed_dir_ff == hbsrc_pkg::DIR_RIGHT);
               rsp_payload_in.led_red       = (committed_dir_ff == hbsrc_pkg::DIR_LEFT);
               rsp_payload_in.speed_percent = pct_ff;
               rsp_payload_in.reversing     = off_ff;
               rsp_valid_in                 = 1'b1;
               state_in                     = hbsrc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hbsrc_pkg::ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbsrc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_right_ff    <= 1'b1;
         prev_left_ff     <= 1'b1;
         committed_dir_ff <= hbsrc_pkg::DIR_RIGHT;
         requested_dir_ff <= hbsrc_pkg::DIR_RIGHT;
         dead_count_ff    <= 8'd0;
         off_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         prev_right_ff    <= prev_right_in;
         prev_left_ff     <= prev_left_in;
         committed_dir_ff <= committed_dir_in;
         requested_dir_ff <= requested_dir_in;
         dead_count_ff    <= dead_count_in;
         off_ff           <= off_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      opnd_ff        <= opnd_in;
      pct_ff         <= pct_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

[src/hbsrc_checker.sv]
// Checker module for the H-bridge controller ports, bound to the top level.
`include "h_bridge_safe_reversal_controller_unit_defines.svh"

module hbsrc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input hbsrc_pkg::rsp_payload_type rsp_payload
);

   logic req_take;
   logic rsp_stall;
   logic bridge_idle;
   logic right_drive_ok;

   assign req_take       = req_valid && req_ready;
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign bridge_idle    = !rsp_payload.high_side_left && !rsp_payload.high_side_right
                           && rsp_payload.duty_left == 8'd0 && rsp_payload.duty_right == 8'd0;
   assign right_drive_ok = rsp_payload.led_right && !rsp_payload.high_side_right
                           && rsp_payload.duty_left == 8'd0;

   // a stalled word holds
   `HBSRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // one word at a time: busy right after an accept
   `HBSRC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, !req_ready)

   // bridge fully off during dead time
   `HBSRC_ASSERT_SAME(a_off_when_reversing, clock, reset, rsp_valid && rsp_payload.reversing, bridge_idle)

   // exactly one LED
   `HBSRC_ASSERT_SAME(a_led_onehot, clock, reset, rsp_valid, rsp_payload.led_right != rsp_payload.led_red)

   // right drive matches the right LED, never shoot-through
   `HBSRC_ASSERT_SAME(a_drive_matches_led, clock, reset, rsp_valid && rsp_payload.high_side_left, right_drive_ok)

endmodule

bind h_bridge_safe_reversal_controller_unit hbsrc_checker u_hbsrc_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench for the H-bridge reversal controller: directed and random ticks checked against a predictor.
module tb;

   // No word may stall longer than this. It covers the long receiver hold-off,
   // the pace of the block and the random idling, with a wide margin.
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int HOLD_AT_WORD     = 60;
   localparam int SAMPLE_FULL      = 4095;
   localparam int DRAIN_CYCLES     = 40;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   hbsrc_pkg::req_payload_type req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   hbsrc_pkg::rsp_payload_type rsp_payload;
   logic                       csr_we      = 1'b0;
   logic                       csr_index   = hbsrc_pkg::CSR_DEAD_TICKS;
   logic [7:0]                 csr_wdata   = '0;

   // Tick words waiting to be offered, and bridge words the block still owes.
   hbsrc_pkg::req_payload_type tick_words_q[$];
   hbsrc_pkg::rsp_payload_type bridge_words_due[$];

   // Idling odds of the current phase, in percent.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   // Set while the driver holds a popped tick word that is not yet accepted.
   bit offer_pending = 1'b0;

   int unsigned fail_count      = 0;
   int unsigned rsp_words_taken = 0;
   int unsigned hold_left       = 0;
   bit          hold_done       = 1'b0;
   int unsigned quiet_cycles    = 0;

   // Predictor copy of the block's state and registers, at their reset values.
   logic       prev_right_lvl = 1'b1;
   logic       prev_left_lvl  = 1'b1;
   logic       dir_committed  = hbsrc_pkg::DIR_RIGHT;
   logic       dir_requested  = hbsrc_pkg::DIR_RIGHT;
   logic [7:0] dead_left      = 8'd0;
   logic [7:0] cfg_dead_ticks = hbsrc_pkg::DEAD_TICKS_RESET;
   logic [7:0] cfg_pwm_max    = hbsrc_pkg::PWM_MAX_RESET;

   h_bridge_safe_reversal_controller_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   // Advance the predicted bridge by one tick and queue the word it must produce.
   task automatic predict_bridge_word(input hbsrc_pkg::req_payload_type w);
      hbsrc_pkg::rsp_payload_type o;
      int unsigned                pct;
      int unsigned                duty;
      logic                       off;
      pct  = (int'(w.speed_sample) * 100) / SAMPLE_FULL;
      duty = (pct * int'(cfg_pwm_max)) / 100;
      if (duty > 255) begin
         duty = 255;
      end
      off = 1'b0;
      if (dead_left != 0) begin
         // Dead time: button edges are dropped, commit on the last tick.
         dead_left = dead_left - 8'd1;
         if (dead_left == 0) begin
            dir_committed = dir_requested;
         end else begin
            off = 1'b1;
         end
      end else begin
         // Left is checked last so it wins when both buttons fall together.
         if (prev_right_lvl && !w.right_button) begin
            dir_requested = hbsrc_pkg::DIR_RIGHT;
         end
         if (prev_left_lvl && !w.left_button) begin
            dir_requested = hbsrc_pkg::DIR_LEFT;
         end
         if (dir_requested != dir_committed) begin
            // A dead_ticks value of zero behaves as one.
            dead_left = (cfg_dead_ticks == 0) ? 8'd1 : cfg_dead_ticks;
            off = 1'b1;
         end
      end
      prev_right_lvl = w.right_button;
      prev_left_lvl  = w.left_button;

      o = '0;
      // Zero duty turns every switch off; the LEDs still follow the direction.
      if (!off && duty != 0) begin
         if (dir_committed == hbsrc_pkg::DIR_RIGHT) begin
            o.high_side_left = 1'b1;
            o.duty_right     = 8'(duty);
         end else begin
            o.high_side_right = 1'b1;
            o.duty_left       = 8'(duty);
         end
      end
      o.led_right     = (dir_committed == hbsrc_pkg::DIR_RIGHT);
      o.led_red       = (dir_committed == hbsrc_pkg::DIR_LEFT);
      o.speed_percent = 7'(pct);
      o.reversing     = off;
      bridge_words_due.push_back(o);
   endtask

   function automatic int check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Driver: offer the next tick word, or idle, once the current one is taken.
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_bridge_word(req_payload);
            offer_pending = 1'b0;
         end
         if (tick_words_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_payload   <= tick_words_q.pop_front();
            req_valid     <= 1'b1;
            offer_pending = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each bridge word taken with the oldest one due, and drive ready.
   always @(posedge clock) begin : monitor
      hbsrc_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_words_taken = rsp_words_taken + 1;
            if (bridge_words_due.size() == 0) begin
               $error("bridge word arrived with nothing due");
               fail_count = fail_count + 1;
            end else begin
               want = bridge_words_due.pop_front();
               fail_count = fail_count
                  + check_field("high_side_left", want.high_side_left,
                                rsp_payload.high_side_left)
                  + check_field("high_side_right", want.high_side_right,
                                rsp_payload.high_side_right)
                  + check_field("duty_left", want.duty_left, rsp_payload.duty_left)
                  + check_field("duty_right", want.duty_right, rsp_payload.duty_right)
                  + check_field("led_right", want.led_right, rsp_payload.led_right)
                  + check_field("led_red", want.led_red, rsp_payload.led_red)
                  + check_field("speed_percent", want.speed_percent,
                                rsp_payload.speed_percent)
                  + check_field("reversing", want.reversing, rsp_payload.reversing);
            end
         end
         // Hold off once for a long stretch so the block backs up into req_ready.
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_words_taken == HOLD_AT_WORD && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run when no word moves on either side for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == hbsrc_pkg::CSR_DEAD_TICKS) begin
         cfg_dead_ticks = value;
      end else begin
         cfg_pwm_max = value;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Block until every tick word is taken and every bridge word is back.
   task automatic wait_drained();
      while (tick_words_q.size() != 0 || offer_pending || bridge_words_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic push_tick(input logic right_lvl, input logic left_lvl, input int sample);
      hbsrc_pkg::req_payload_type w;
      w.right_button = right_lvl;
      w.left_button  = left_lvl;
      w.speed_sample = 12'(sample);
      tick_words_q.push_back(w);
   endtask

   // Mostly released buttons with short presses, so reversals start and finish;
   // samples favor the scale ends now and then.
   task automatic queue_random_ticks(input int count, input int unsigned send_pct,
                                     input int unsigned recv_pct);
      int sample;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0:       sample = 0;
            1:       sample = SAMPLE_FULL;
            default: sample = $urandom_range(0, SAMPLE_FULL);
         endcase
         push_tick($urandom_range(0, 99) >= 12, $urandom_range(0, 99) >= 12, sample);
      end
   endtask

   initial begin : sequencer
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks with the shortest dead time; zero stands for one tick.
      write_csr(hbsrc_pkg::CSR_DEAD_TICKS, 8'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      push_tick(1, 1, 0);             // scale ends while driving right
      push_tick(1, 1, SAMPLE_FULL);
      push_tick(1, 1, 1);
      push_tick(1, 1, SAMPLE_FULL - 1);
      push_tick(1, 1, 2048);
      push_tick(1, 0, SAMPLE_FULL);   // left press starts a reversal
      push_tick(0, 0, 3000);          // right edge inside the dead time is dropped
      push_tick(1, 1, 3000);
      push_tick(0, 1, SAMPLE_FULL);   // right press reverses back
      push_tick(1, 1, 100);
      push_tick(0, 0, SAMPLE_FULL);   // both fall together: left wins
      push_tick(1, 1, SAMPLE_FULL);
      push_tick(1, 0, SAMPLE_FULL);   // press for the current direction
      push_tick(1, 1, 0);             // zero duty while driving left
      push_tick(0, 1, 0);             // reversal at zero duty
      push_tick(1, 1, 2000);
      push_tick(0, 1, SAMPLE_FULL);   // press for the current direction again
      push_tick(1, 1, SAMPLE_FULL);
      wait_drained();

      // Reset dead time, no idling; the long hold-off falls in this phase.
      write_csr(hbsrc_pkg::CSR_DEAD_TICKS, hbsrc_pkg::DEAD_TICKS_RESET);
      queue_random_ticks(200, 0, 0);
      wait_drained();

      write_csr(hbsrc_pkg::CSR_DEAD_TICKS, 8'd1);
      write_csr(hbsrc_pkg::CSR_PWM_MAX, 8'd0);
      queue_random_ticks(250, 72, 0);
      wait_drained();

      write_csr(hbsrc_pkg::CSR_DEAD_TICKS, 8'd255);
      write_csr(hbsrc_pkg::CSR_PWM_MAX, 8'd128);
      queue_random_ticks(300, 0, 72);
      wait_drained();

      write_csr(hbsrc_pkg::CSR_DEAD_TICKS, 8'($urandom_range(2, 20)));
      write_csr(hbsrc_pkg::CSR_PWM_MAX, 8'd1);
      queue_random_ticks(250, 30, 30);
      wait_drained();

      write_csr(hbsrc_pkg::CSR_DEAD_TICKS, 8'd3);
      write_csr(hbsrc_pkg::CSR_PWM_MAX, 8'($urandom_range(2, 254)));
      queue_random_ticks(300, 0, 0);
      wait_drained();

      // Let any stray word surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
